// ===== rtl/core/bcrc_pkg.sv =====
// shared types, codes and sizes of the block cache tag and policy engine
package bcrc_pkg;

  // default sizes and fixed field widths
  localparam int DEF_SLOTS    = 16;
  localparam int DEF_REF_BITS = 8;
  localparam int MAX_RESULTS  = 16;
  localparam int BLOCK_W      = 32;
  localparam int CMD_W        = 3;
  localparam int SIDX_W       = 4;
  localparam int STATUS_W     = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DIRTY   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISCARD = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

  // sequencer state
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_END
  } state_t;

  // what the current scan is doing
  typedef enum logic [2:0] {
    PH_LOOKUP,
    PH_VICTIM,
    PH_FLUSH,
    PH_SLOT,
    PH_NONE
  } phase_t;

  // input beat
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [BLOCK_W-1:0] block_number;
    logic [SIDX_W-1:0]  slot_index;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [SIDX_W-1:0]   slot_out;
    logic                hit;
    logic                fill_needed;
    logic                writeback_valid;
    logic [BLOCK_W-1:0]  writeback_block;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

  // flags from the shared slot compare unit
  typedef struct packed {
    logic match;
    logic unref;
    logic live;
    logic dirty_live;
  } slot_flags_t;

endpackage

// ===== rtl/core/bcrc_chan_if.sv =====
// valid/ready channel carrying one payload beat
interface bcrc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/block_cache_refcount_clock_unit.sv =====
// top level: sequencer, slot state and result register of the block cache engine
//
//  channel  dir  handshake          beat
//  in_ch    in   valid/ready        cmd, block_number, slot_index
//  out_ch   out  valid/ready        slot_out, hit, fill_needed, writeback_valid,
//                                   writeback_block, status, last
//
// each visited slot takes a row read from the tag store (ST_RD), then an
// evaluation in the shared compare unit (ST_EV); refs and dirty written back.
// dirty, release, discard and unused codes: one slot visit, then the result.
// get: slots 0 to k for a hit at slot k, all slots on a free fill, then the
// round-robin victim scan if none is free. flush: slots from the scan pointer.
// reset clears valid bits, scan pointer and control; no clearing pass.
// a full result register stalls the sequencer; in_ch.ready only while idle.
module block_cache_refcount_clock_unit #(
  parameter int SLOTS    = bcrc_pkg::DEF_SLOTS,
  parameter int REF_BITS = bcrc_pkg::DEF_REF_BITS
) (
  input logic         clk,
  input logic         rst_n,
  bcrc_chan_if.sink   in_ch,
  bcrc_chan_if.source out_ch
);
  import bcrc_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int ROW_W  = BLOCK_W + REF_BITS + 1;
  localparam int NRES_W = $clog2(MAX_RESULTS + 1);
  localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [REF_BITS-1:0] REF_MAX   = {REF_BITS{1'b1}};
  localparam logic [NRES_W-1:0]   NRES_CAP  = NRES_W'(MAX_RESULTS - 1);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
  endfunction

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [BLOCK_W-1:0]   key_r, key_nxt;
  logic [SIDX_W-1:0]    sidx_r, sidx_nxt;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic [SLOT_W-1:0]    cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]    scan_ptr_r, scan_ptr_nxt;
  logic                 free_v_r, free_v_nxt;
  logic [SLOT_W-1:0]    free_idx_r, free_idx_nxt;
  logic                 held_v_r, held_v_nxt;
  result_t              held_r, held_nxt;
  logic [NRES_W-1:0]    nres_r, nres_nxt;
  logic [SLOTS-1:0]     valid_r, valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_data_r, out_data_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic                 cur_valid;
  logic                 inrange;
  logic [ROW_W-1:0]     rd_row;
  logic [BLOCK_W-1:0]   row_block;
  logic [REF_BITS-1:0]  row_refs;
  logic                 row_dirty;
  logic [REF_BITS-1:0]  refs_inc;
  logic [REF_BITS-1:0]  refs_dec;
  logic [ROW_W-1:0]     new_row;
  logic [SLOT_W-1:0]    free_addr;
  slot_flags_t          flags;

  logic                 push;
  logic                 stall;
  result_t              push_res;
  logic                 go_idle, go_end, go_victim;
  logic                 act_hit, act_alloc, act_victim, act_flush;
  logic                 act_dirty, act_release, act_discard;
  logic                 step;

  logic                 mem_rd_en;
  logic                 mem_wr_en;
  logic [SLOT_W-1:0]    mem_wr_addr;
  logic [ROW_W-1:0]     mem_wr_data;

  // handshake
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // row fields and derived values
  assign row_block = rd_row[ROW_W-1 -: BLOCK_W];
  assign row_refs  = rd_row[REF_BITS:1];
  assign row_dirty = rd_row[0];
  assign refs_inc  = (row_refs == REF_MAX) ? row_refs : row_refs + REF_BITS'(1);
  assign refs_dec  = row_refs - REF_BITS'(1);
  assign new_row   = {key_r, REF_BITS'(1), 1'b0};
  assign cur_valid = valid_r[idx_r];
  assign inrange   = (32'(sidx_r) < SLOTS);
  assign free_addr = free_v_r ? free_idx_r : idx_r;

  bcrc_tag_mem #(
    .DEPTH  (SLOTS),
    .WIDTH  (ROW_W),
    .ADDR_W (SLOT_W)
  ) u_tag_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_row),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  bcrc_slot_eval #(
    .REF_BITS (REF_BITS)
  ) u_slot_eval (
    .slot_vld  (cur_valid),
    .row_block (row_block),
    .row_refs  (row_refs),
    .row_dirty (row_dirty),
    .key       (key_r),
    .flags     (flags)
  );

  // per-slot decision of the sequencer
  always_comb begin
    push        = 1'b0;
    push_res    = '0;
    push_res.last = 1'b1;
    go_idle     = 1'b0;
    go_end      = 1'b0;
    go_victim   = 1'b0;
    act_hit     = 1'b0;
    act_alloc   = 1'b0;
    act_victim  = 1'b0;
    act_flush   = 1'b0;
    act_dirty   = 1'b0;
    act_release = 1'b0;
    act_discard = 1'b0;
    if (state_r == ST_EV) begin
      case (phase_r)
        PH_LOOKUP: begin
          if (flags.match) begin
            act_hit           = 1'b1;
            push              = 1'b1;
            push_res.slot_out = SIDX_W'(idx_r);
            push_res.hit      = 1'b1;
            go_idle           = 1'b1;
          end else if (idx_r == LAST_SLOT) begin
            if (free_v_r || !cur_valid) begin
              act_alloc            = 1'b1;
              push                 = 1'b1;
              push_res.slot_out    = SIDX_W'(free_addr);
              push_res.fill_needed = 1'b1;
              go_idle              = 1'b1;
            end else begin
              go_victim = 1'b1;
            end
          end
        end
        PH_VICTIM: begin
          if (flags.unref) begin
            act_victim               = 1'b1;
            push                     = 1'b1;
            push_res.slot_out        = SIDX_W'(idx_r);
            push_res.fill_needed     = 1'b1;
            push_res.writeback_valid = row_dirty;
            push_res.writeback_block = row_dirty ? row_block : '0;
            go_idle                  = 1'b1;
          end else if (cnt_r == LAST_SLOT) begin
            push            = 1'b1;
            push_res.status = STATUS_FULL;
            go_idle         = 1'b1;
          end
        end
        PH_FLUSH: begin
          if (flags.dirty_live) begin
            act_flush = 1'b1;
            push      = held_v_r;
            push_res  = held_r;
          end
          go_end = (cnt_r == LAST_SLOT) || (flags.dirty_live && (nres_r == NRES_CAP));
        end
        PH_SLOT: begin
          push              = 1'b1;
          push_res.slot_out = sidx_r;
          go_idle           = 1'b1;
          if (inrange && cur_valid && ((cmd_r == CMD_DISCARD) || flags.live)) begin
            act_dirty   = (cmd_r == CMD_DIRTY);
            act_release = (cmd_r == CMD_RELEASE);
            act_discard = (cmd_r == CMD_DISCARD);
          end else begin
            push_res.status = STATUS_BAD;
          end
        end
        default: begin
          push    = 1'b1;
          go_idle = 1'b1;
        end
      endcase
    end else if (state_r == ST_END) begin
      push    = 1'b1;
      go_idle = 1'b1;
      if (held_v_r) begin
        push_res      = held_r;
        push_res.last = 1'b1;
      end
    end
    stall = push && !out_free;
    step  = (state_r == ST_EV) && !stall;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_EV;
      end
      ST_EV: begin
        if (stall) begin
          state_nxt = ST_EV;
        end else if (go_idle) begin
          state_nxt = ST_IDLE;
        end else if (go_end) begin
          state_nxt = ST_END;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_END: begin
        if (!stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath, slot state and memory access
  always_comb begin
    phase_nxt    = phase_r;
    cmd_nxt      = cmd_r;
    key_nxt      = key_r;
    sidx_nxt     = sidx_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    scan_ptr_nxt = scan_ptr_r;
    free_v_nxt   = free_v_r;
    free_idx_nxt = free_idx_r;
    held_v_nxt   = held_v_r;
    held_nxt     = held_r;
    nres_nxt     = nres_r;
    valid_nxt    = valid_r;
    mem_rd_en    = (state_r == ST_RD);
    mem_wr_en    = 1'b0;
    mem_wr_addr  = idx_r;
    mem_wr_data  = {row_block, row_refs, row_dirty};

    // new command
    if (in_acc) begin
      cmd_nxt    = in_ch.data.cmd;
      key_nxt    = in_ch.data.block_number;
      sidx_nxt   = in_ch.data.slot_index;
      cnt_nxt    = '0;
      free_v_nxt = 1'b0;
      held_v_nxt = 1'b0;
      nres_nxt   = '0;
      idx_nxt    = '0;
      case (in_ch.data.cmd)
        CMD_GET: begin
          phase_nxt = PH_LOOKUP;
        end
        CMD_FLUSH: begin
          phase_nxt = PH_FLUSH;
          idx_nxt   = scan_ptr_r;
        end
        CMD_DIRTY, CMD_RELEASE, CMD_DISCARD: begin
          phase_nxt = PH_SLOT;
          if (32'(in_ch.data.slot_index) < SLOTS) begin
            idx_nxt = SLOT_W'(in_ch.data.slot_index);
          end
        end
        default: begin
          phase_nxt = PH_NONE;
        end
      endcase
    end

    // advance the scan
    if (step) begin
      if (go_victim) begin
        phase_nxt = PH_VICTIM;
        idx_nxt   = scan_ptr_r;
        cnt_nxt   = '0;
      end else begin
        idx_nxt = next_slot(idx_r);
        cnt_nxt = cnt_r + SLOT_W'(1);
      end
      if ((phase_r == PH_LOOKUP) && !cur_valid && !free_v_r) begin
        free_v_nxt   = 1'b1;
        free_idx_nxt = idx_r;
      end
      if (act_hit) begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {row_block, refs_inc, row_dirty};
      end
      if (act_alloc) begin
        mem_wr_en            = 1'b1;
        mem_wr_addr          = free_addr;
        mem_wr_data          = new_row;
        valid_nxt[free_addr] = 1'b1;
      end
      if (act_victim) begin
        mem_wr_en    = 1'b1;
        mem_wr_data  = new_row;
        scan_ptr_nxt = next_slot(idx_r);
      end
      if (act_flush) begin
        mem_wr_en                = 1'b1;
        mem_wr_data              = {row_block, row_refs, 1'b0};
        held_v_nxt               = 1'b1;
        held_nxt                 = '0;
        held_nxt.slot_out        = SIDX_W'(idx_r);
        held_nxt.writeback_valid = 1'b1;
        held_nxt.writeback_block = row_block;
        nres_nxt                 = nres_r + NRES_W'(1);
      end
      if (act_dirty) begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {row_block, row_refs, 1'b1};
      end
      if (act_release) begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {row_block, refs_dec, row_dirty};
      end
      if (act_discard) begin
        valid_nxt[idx_r] = 1'b0;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    if (push && !stall) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = push_res;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_NONE;
      scan_ptr_r  <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      free_v_r    <= 1'b0;
      held_v_r    <= 1'b0;
      cnt_r       <= '0;
      nres_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      free_v_r    <= free_v_nxt;
      held_v_r    <= held_v_nxt;
      cnt_r       <= cnt_nxt;
      nres_r      <= nres_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    sidx_r     <= sidx_nxt;
    idx_r      <= idx_nxt;
    free_idx_r <= free_idx_nxt;
    held_r     <= held_nxt;
    out_data_r <= out_data_nxt;
  end

  // slot valid bits only move while a slot is being evaluated
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_EV) |=> $stable(valid_r))
    else $error("slot valid bits changed outside evaluation");

  // scan pointer only moves on a victim pick
  assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == ST_EV && phase_r == PH_VICTIM) |=> $stable(scan_ptr_r))
    else $error("scan pointer moved outside victim scan");

  // no writeback block without writeback
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.writeback_valid |-> (out_data_r.writeback_block == '0))
    else $error("writeback block set without writeback");

  // a hit needs no fill and no writeback
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.hit |->
      !out_data_r.fill_needed && !out_data_r.writeback_valid &&
      (out_data_r.status == STATUS_OK) && out_data_r.last)
    else $error("hit result with fill or writeback");

endmodule

// ===== rtl/core/bcrc_tag_mem.sv =====
// slot row store: block number, reference count and dirty mark per slot
module bcrc_tag_mem #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 41,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/bcrc_slot_eval.sv =====
// shared compare unit: classifies the slot row currently read
module bcrc_slot_eval #(
  parameter int REF_BITS = bcrc_pkg::DEF_REF_BITS
) (
  input  logic                         slot_vld,
  input  logic [bcrc_pkg::BLOCK_W-1:0] row_block,
  input  logic [REF_BITS-1:0]          row_refs,
  input  logic                         row_dirty,
  input  logic [bcrc_pkg::BLOCK_W-1:0] key,
  output bcrc_pkg::slot_flags_t        flags
);
  import bcrc_pkg::*;

  // tag compare and reference checks
  always_comb begin
    flags.match      = slot_vld && (row_block == key);
    flags.unref      = (row_refs == '0);
    flags.live       = slot_vld && (row_refs != '0);
    flags.dirty_live = slot_vld && row_dirty;
  end

endmodule
